// File: design/a128x4_pkg.sv
// Package for the AEGIS-128X4 core step block: payload structs, opcodes,
// the AES S-box and the lane round function. No dependencies.
`default_nettype none
package a128x4_pkg;

  localparam int VecWords = 8;
  localparam int NumVecs  = 8;

  typedef enum logic [2:0] {
    OP_ABSORB  = 3'd0,
    OP_ENCRYPT = 3'd1,
    OP_DECRYPT = 3'd2,
    OP_WRITE   = 3'd3,
    OP_READ    = 3'd4
  } opcode_t;

  typedef logic [511:0] vec_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        second_half;
    logic [2:0]  vector_index;
    logic [63:0] word_7;
    logic [63:0] word_6;
    logic [63:0] word_5;
    logic [63:0] word_4;
    logic [63:0] word_3;
    logic [63:0] word_2;
    logic [63:0] word_1;
    logic [63:0] word_0;
  } in_word_t;

  typedef struct packed {
    logic [63:0] out_7;
    logic [63:0] out_6;
    logic [63:0] out_5;
    logic [63:0] out_4;
    logic [63:0] out_3;
    logic [63:0] out_2;
    logic [63:0] out_1;
    logic [63:0] out_0;
  } out_word_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // One AES encryption round on a 128-bit lane, byte i at bits 8i+7:8i.
  function automatic logic [127:0] aes_round(input logic [127:0] src,
                                             input logic [127:0] key);
    logic [7:0] b [16];
    logic [7:0] x0, x1, x2, x3, al;
    logic [127:0] res;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        b[r + 4*c] = SBOX[src[8*(r + 4*((c + r) % 4)) +: 8]];
      end
    end
    res = '0;
    for (int c = 0; c < 4; c++) begin
      x0 = b[4*c];
      x1 = b[4*c+1];
      x2 = b[4*c+2];
      x3 = b[4*c+3];
      al = x0 ^ x1 ^ x2 ^ x3;
      res[32*c +: 8]      = x0 ^ al ^ xtime(x0 ^ x1);
      res[32*c + 8 +: 8]  = x1 ^ al ^ xtime(x1 ^ x2);
      res[32*c + 16 +: 8] = x2 ^ al ^ xtime(x2 ^ x3);
      res[32*c + 24 +: 8] = x3 ^ al ^ xtime(x3 ^ x0);
    end
    aes_round = res ^ key;
  endfunction

endpackage
`default_nettype wire

// File: design/aegis128x4_core_step_top.sv
// AEGIS-128X4 core step: eight 512-bit state vectors, keystream XOR and
// state update. Depends on a128x4_pkg.
//
// Usage: in_valid/in_stall carry one word per item: opcode, half select,
// vector index and a 512-bit half chunk. out_valid/out_stall return one
// 512-bit word for encrypt, decrypt and state read; absorb, state write and
// unused opcodes return nothing.
// A result reaches the output register in the cycle after acceptance.
// Throughput: one item per cycle unless stalled; the state update (one AES
// round per lane, eight vectors in parallel) completes in the accept cycle.
// in_stall is high only while a result is held and out_stall is high, so a
// stalled receiver blocks input; while the output is free or being taken,
// a new item is accepted every cycle.
// Reset (rst_n low, synchronous) clears the state, the held half and
// out_valid.
`default_nettype none
module aegis128x4_core_step_top (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire a128x4_pkg::in_word_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output a128x4_pkg::out_word_t      out_data
);
  import a128x4_pkg::*;

  vec_t       st_r [NumVecs];
  vec_t       st_nxt [NumVecs];
  vec_t       held_r, held_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_data_r, out_data_nxt;

  logic       acc;
  vec_t       din, res, pt;
  logic       is_data;

  assign in_stall  = out_valid_r && out_stall;
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign din = {in_data.word_7, in_data.word_6, in_data.word_5, in_data.word_4,
                in_data.word_3, in_data.word_2, in_data.word_1, in_data.word_0};
  assign is_data = (in_data.opcode == OP_ABSORB) || (in_data.opcode == OP_ENCRYPT)
                || (in_data.opcode == OP_DECRYPT);
  assign res = in_data.second_half
             ? (din ^ st_r[5] ^ st_r[2] ^ (st_r[6] & st_r[7]))
             : (din ^ st_r[6] ^ st_r[1] ^ (st_r[2] & st_r[3]));
  assign pt = (in_data.opcode == OP_DECRYPT) ? res : din;

  always_comb begin
    for (int v = 0; v < NumVecs; v++) st_nxt[v] = st_r[v];
    held_nxt      = held_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (acc) begin
      case (in_data.opcode)
        OP_ABSORB, OP_ENCRYPT, OP_DECRYPT: begin
          if (!in_data.second_half) begin
            held_nxt = pt;
          end else begin
            for (int v = 0; v < NumVecs; v++) begin
              for (int l = 0; l < 4; l++) begin
                st_nxt[v][128*l +: 128] =
                  aes_round(st_r[(v + NumVecs - 1) % NumVecs][128*l +: 128],
                            st_r[v][128*l +: 128]);
              end
            end
            st_nxt[0] = st_nxt[0] ^ held_r;
            st_nxt[4] = st_nxt[4] ^ pt;
          end
          if (in_data.opcode != OP_ABSORB) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = res;
          end
        end
        OP_WRITE: begin
          st_nxt[in_data.vector_index] = din;
        end
        OP_READ: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = st_r[in_data.vector_index];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < NumVecs; v++) st_r[v] <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int v = 0; v < NumVecs; v++) st_r[v] <= st_nxt[v];
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("result lost under stall");
  a_read: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.opcode == OP_READ |=> out_valid_r)
    else $error("read gave no result");
  a_absorb: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (in_data.opcode == OP_ABSORB || in_data.opcode == OP_WRITE) && !out_stall
    |=> !out_valid_r)
    else $error("spurious result");
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    acc && is_data && !in_data.second_half |=> $stable(st_r[0]) && $stable(st_r[4]))
    else $error("first half changed state");

endmodule
`default_nettype wire

// File: tb/tb_aegis128x4_core_step_top.sv
// Testbench for aegis128x4_core_step_top: directed table then random chunks,
// checked against an in-bench AEGIS-128X4 state predictor. Depends on a128x4_pkg.
`timescale 1ns / 1ps
module tb_aegis128x4_core_step_top;
  import a128x4_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd5;
  localparam logic [2:0] OP_RSVD6  = 3'd6;
  localparam logic [2:0] OP_RSVD7  = 3'd7;
  localparam int StallLimit = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;

  aegis128x4_core_step_top uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  vec_t cipher_vec [8];
  vec_t held_half;
  vec_t expected_words [$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  // SubBytes/ShiftRows/MixColumns on one 128-bit lane, then XOR key.
  function automatic logic [127:0] lane_round(logic [127:0] src, logic [127:0] key);
    logic [7:0] sb [16];
    logic [7:0] a0, a1, a2, a3, t;
    logic [127:0] mixed;
    logic [7:0] d;
    mixed = '0;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        sb[r + 4*c] = SBOX[src[8*(r + 4*((c + r) & 3)) +: 8]];
    for (int c = 0; c < 4; c++) begin
      a0 = sb[4*c]; a1 = sb[4*c+1]; a2 = sb[4*c+2]; a3 = sb[4*c+3];
      t = a0 ^ a1 ^ a2 ^ a3;
      d = a0 ^ a1; mixed[32*c +: 8]      = a0 ^ t ^ ({d[6:0], 1'b0} ^ (d[7] ? 8'h1b : 8'h00));
      d = a1 ^ a2; mixed[32*c + 8 +: 8]  = a1 ^ t ^ ({d[6:0], 1'b0} ^ (d[7] ? 8'h1b : 8'h00));
      d = a2 ^ a3; mixed[32*c + 16 +: 8] = a2 ^ t ^ ({d[6:0], 1'b0} ^ (d[7] ? 8'h1b : 8'h00));
      d = a3 ^ a0; mixed[32*c + 24 +: 8] = a3 ^ t ^ ({d[6:0], 1'b0} ^ (d[7] ? 8'h1b : 8'h00));
    end
    return mixed ^ key;
  endfunction

  function automatic vec_t payload_vec(in_word_t w);
    return {w.word_7, w.word_6, w.word_5, w.word_4, w.word_3, w.word_2, w.word_1, w.word_0};
  endfunction

  // Advances the cipher state for one word; returns 1 with the 512-bit answer if any.
  function automatic bit cipher_step(in_word_t w, output vec_t answer);
    vec_t din, ks, pt;
    vec_t nxt [8];
    din = payload_vec(w);
    answer = '0;
    case (w.opcode)
      OP_ABSORB, OP_ENCRYPT, OP_DECRYPT: begin
        if (!w.second_half)
          ks = cipher_vec[6] ^ cipher_vec[1] ^ (cipher_vec[2] & cipher_vec[3]);
        else
          ks = cipher_vec[5] ^ cipher_vec[2] ^ (cipher_vec[6] & cipher_vec[7]);
        answer = din ^ ks;
        pt = (w.opcode == OP_DECRYPT) ? answer : din;
        if (!w.second_half) begin
          held_half = pt;
        end else begin
          for (int v = 0; v < 8; v++)
            for (int l = 0; l < 4; l++)
              nxt[v][128*l +: 128] = lane_round(cipher_vec[(v + 7) % 8][128*l +: 128],
                                                cipher_vec[v][128*l +: 128]);
          nxt[0] ^= held_half;
          nxt[4] ^= pt;
          cipher_vec = nxt;
        end
        return w.opcode != OP_ABSORB;
      end
      OP_WRITE: begin
        cipher_vec[w.vector_index] = din;
        return 1'b0;
      end
      OP_READ: begin
        answer = cipher_vec[w.vector_index];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic in_word_t make_word(logic [2:0] op, logic half, logic [2:0] vi,
                                         vec_t data);
    in_word_t w;
    w = '0;
    w.opcode = op;
    w.second_half = half;
    w.vector_index = vi;
    {w.word_7, w.word_6, w.word_5, w.word_4, w.word_3, w.word_2, w.word_1, w.word_0} = data;
    return w;
  endfunction

  function automatic vec_t rand_vec();
    vec_t v;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 16; i++) v[32*i +: 32] = $urandom;
    if (mode == 0) v = '0;
    else if (mode == 1) v = '1;
    return v;
  endfunction

  typedef struct {
    in_word_t w;
    bit has_fixed;
    vec_t fixed;
  } stim_row_t;

  stim_row_t stim_table [$];
  in_word_t send_queue [$];

  task automatic add_row(logic [2:0] op, logic half, logic [2:0] vi, vec_t data,
                         bit has_fixed, vec_t fixed);
    stim_row_t r;
    r.w = make_word(op, half, vi, data);
    r.has_fixed = has_fixed;
    r.fixed = fixed;
    stim_table.push_back(r);
  endtask

  task automatic send_word(in_word_t w);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // Predict at acceptance so ordering matches the block exactly.
  always @(posedge clk) begin
    vec_t ans;
    if (rst_n && in_valid && !in_stall) begin
      if (cipher_step(in_data, ans)) expected_words.push_back(ans);
    end
  end

  always @(posedge clk) begin
    vec_t exp_v, act_v;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected output word %h", out_data);
        errors++;
      end else begin
        exp_v = expected_words.pop_front();
        act_v = out_data;
        for (int i = 0; i < 8; i++)
          if (exp_v[64*i +: 64] !== act_v[64*i +: 64]) begin
            $error("out_%0d expected %h actual %h", i, exp_v[64*i +: 64], act_v[64*i +: 64]);
            errors++;
          end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls with one long hold-off stretch.
  initial begin
    int wait_n;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      if (stim_done && expected_words.size() == 0) wait_n = 0;
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    vec_t ans, pat;
    logic [2:0] op;
    logic [2:0] vi;
    int chunks;
    bit pressure_set;
    pressure_set = 1'b0;
    for (int v = 0; v < 8; v++) cipher_vec[v] = '0;
    held_half = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pat = {8{64'h0123_4567_89ab_cdef}};
    add_row(OP_READ, 1'b0, 3'd0, '0, 1'b1, '0);
    add_row(OP_READ, 1'b1, 3'd7, '1, 1'b1, '0);
    add_row(OP_ENCRYPT, 1'b0, 3'd0, '1, 1'b1, '1);
    add_row(OP_ENCRYPT, 1'b1, 3'd0, '1, 1'b1, '1);
    add_row(OP_WRITE, 1'b0, 3'd0, '1, 1'b0, '0);
    add_row(OP_READ, 1'b0, 3'd0, '0, 1'b1, '1);
    add_row(OP_WRITE, 1'b1, 3'd7, pat, 1'b0, '0);
    add_row(OP_READ, 1'b0, 3'd7, '0, 1'b1, pat);
    add_row(OP_UNUSED, 1'b0, 3'd7, '1, 1'b0, '0);
    add_row(OP_RSVD6, 1'b1, 3'd3, pat, 1'b0, '0);
    add_row(OP_RSVD7, 1'b1, 3'd5, '1, 1'b0, '0);
    for (int v = 1; v < 7; v++) add_row(OP_WRITE, 1'b0, v[2:0], pat << v, 1'b0, '0);
    add_row(OP_ABSORB, 1'b0, 3'd0, pat, 1'b0, '0);
    add_row(OP_ABSORB, 1'b1, 3'd0, ~pat, 1'b0, '0);
    add_row(OP_DECRYPT, 1'b0, 3'd0, '1, 1'b0, '0);
    add_row(OP_DECRYPT, 1'b1, 3'd0, '0, 1'b0, '0);
    add_row(OP_ENCRYPT, 1'b1, 3'd0, pat, 1'b0, '0);
    add_row(OP_ENCRYPT, 1'b0, 3'd0, pat, 1'b0, '0);
    add_row(OP_DECRYPT, 1'b1, 3'd0, '1, 1'b0, '0);
    add_row(OP_READ, 1'b0, 3'd4, '0, 1'b0, '0);
    foreach (stim_table[i]) begin
      send_word(stim_table[i].w);
      in_valid <= 1'b0;
      @(negedge clk);
      if (stim_table[i].has_fixed && expected_words.size() > 0
          && expected_words[$] !== stim_table[i].fixed) begin
        $error("table row %0d expected %h predicted %h", i, stim_table[i].fixed,
               expected_words[$]);
        errors++;
      end
      @(posedge clk);
    end

    chunks = 0;
    while (chunks < 1400) begin
      if (!pressure_set && chunks >= 300) begin
        hold_off = 1'b1;
        pressure_set = 1'b1;
      end
      if ($urandom_range(0, 9) < 8) begin
        op = 3'($urandom_range(0, 2));
        send_word(make_word(op, 1'b0, 3'($urandom_range(0, 7)), rand_vec()));
        if ($urandom_range(0, 9) == 0) op = 3'($urandom_range(0, 2));
        send_word(make_word(op, 1'b1, 3'($urandom_range(0, 7)), rand_vec()));
        chunks += 2;
      end else begin
        vi = 3'($urandom_range(0, 7));
        op = 3'($urandom_range(0, 7));
        if (op < OP_WRITE) op = OP_READ;
        send_word(make_word(op, 1'($urandom_range(0, 1)), vi, rand_vec()));
        chunks++;
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
    while (expected_words.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: aegis128x4_core_step_top.f
design/a128x4_pkg.sv
design/aegis128x4_core_step_top.sv
tb/tb_aegis128x4_core_step_top.sv
